[hw/rtl/assert_macros.svh]
// Assertion macros used by the sequencer top module.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and disabled while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/owus_pkg.sv]
package owus_pkg;

  // Command codes on the input channel.
  typedef enum logic [1:0] {
    FUNC_RESET = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_RX    = 2'd3
  } func_t;

  // Operation in progress.
  typedef enum logic [1:0] {
    OP_FREE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLOT_ONE  = 2'd0;
  localparam logic [1:0] CFG_SLOT_ZERO = 2'd1;
  localparam logic [1:0] CFG_RESET_PAT = 2'd2;

  localparam logic [7:0] SLOT_ONE_RST  = 8'hFF;
  localparam logic [7:0] SLOT_ZERO_RST = 8'h00;
  localparam logic [7:0] RESET_PAT_RST = 8'hF0;

  // Index of the last slot of a byte.
  localparam logic [3:0] LAST_BIT  = 4'd7;
  localparam logic [3:0] BYTE_BITS = 4'd8;

endpackage

[hw/rtl/onewire_uart_slot_sequencer_top.sv]
// One-wire bus master that talks to the bus through a UART, one UART byte
// per bus slot. Each input transfer carries a command (start a bus reset,
// start a byte write, start a byte read) or a byte received from the UART.
// Every input transfer yields exactly one result transfer that tells the
// UART which slot byte to send next, which baud rate to use, whether the
// operation finished, the read byte and the presence status.
// The configuration port writes the slot patterns and the reset pattern; the
// user must write it only while no transfer is in flight, as no logic checks it.
// A result passes through the input register and then the result register
// before it appears on the output.
// Throughput is one transfer per cycle while the receiver does not stall; the
// combinational next-state logic between the two registers sets that figure.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more item, after which in_stall rises.
// Reset clears the pipeline, returns the sequencer to the free state at fast
// baud and loads the configuration registers with their default patterns.
module onewire_uart_slot_sequencer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  owus_pkg::func_t      in_func,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic                 out_tx_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_baud_slow,
  output logic                 out_done_res,
  output logic [7:0]           out_read_value,
  output logic                 out_device_present,
  output logic                 out_busy_flag
);
  import owus_pkg::*;

  // Configuration registers.
  logic [7:0] slot_one_r, slot_zero_r, reset_pat_r;

  // Input register stage.
  logic       in_valid_r;
  func_t      in_func_r;
  logic [7:0] in_data_r;

  // Sequencer state.
  op_t        op_r, op_nxt;
  logic       busy_r, busy_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [7:0] write_shift_r, write_shift_nxt;
  logic [7:0] read_accum_r, read_accum_nxt;
  logic [7:0] presence_r, presence_nxt;
  logic       reset_phase_r, reset_phase_nxt;
  logic       slow_baud_r, slow_baud_nxt;

  // Result register.
  logic       out_valid_r;
  logic       status_nxt, tx_valid_nxt, done_nxt;
  logic [7:0] tx_byte_nxt;
  logic       status_r, tx_valid_r, done_r, present_r;
  logic [7:0] tx_byte_r;

  logic       in_accept;
  logic       advance;
  logic [3:0] bit_inc;

  // The item in the input register moves on when the result register is
  // empty or is being emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign bit_inc   = bit_index_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_one_r  <= SLOT_ONE_RST;
      slot_zero_r <= SLOT_ZERO_RST;
      reset_pat_r <= RESET_PAT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SLOT_ONE:  slot_one_r  <= cfg_data;
        CFG_SLOT_ZERO: slot_zero_r <= cfg_data;
        CFG_RESET_PAT: reset_pat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_func_r <= in_func;
      in_data_r <= in_data_byte;
    end
  end

  // Next state and result for the item in the input register.
  always_comb begin
    op_nxt          = op_r;
    busy_nxt        = busy_r;
    bit_index_nxt   = bit_index_r;
    write_shift_nxt = write_shift_r;
    read_accum_nxt  = read_accum_r;
    presence_nxt    = presence_r;
    reset_phase_nxt = reset_phase_r;
    slow_baud_nxt   = slow_baud_r;
    status_nxt      = 1'b0;
    tx_valid_nxt    = 1'b0;
    tx_byte_nxt     = 8'h00;
    done_nxt        = 1'b0;

    if (in_func_r != FUNC_RX) begin
      if (busy_r) begin
        status_nxt = 1'b1;
      end else begin
        busy_nxt     = 1'b1;
        tx_valid_nxt = 1'b1;
        case (in_func_r)
          FUNC_RESET: begin
            op_nxt          = OP_RESET;
            reset_phase_nxt = 1'b0;
            slow_baud_nxt   = 1'b1;
            tx_byte_nxt     = reset_pat_r;
          end
          FUNC_WRITE: begin
            op_nxt          = OP_WRITE;
            write_shift_nxt = in_data_r;
            bit_index_nxt   = 4'd0;
            tx_byte_nxt     = in_data_r[0] ? slot_one_r : slot_zero_r;
          end
          default: begin
            op_nxt         = OP_READ;
            read_accum_nxt = 8'h00;
            bit_index_nxt  = 4'd0;
            tx_byte_nxt    = slot_one_r;
          end
        endcase
      end
    end else begin
      case (op_r)
        OP_WRITE: begin
          if (bit_index_r < LAST_BIT) begin
            bit_index_nxt = bit_inc;
            tx_valid_nxt  = 1'b1;
            tx_byte_nxt   = write_shift_r[bit_inc[2:0]] ? slot_one_r : slot_zero_r;
          end else begin
            busy_nxt = 1'b0;
            op_nxt   = OP_FREE;
            done_nxt = 1'b1;
          end
        end
        OP_READ: begin
          if (in_data_r == slot_one_r && bit_index_r < BYTE_BITS) begin
            read_accum_nxt[bit_index_r[2:0]] = 1'b1;
          end
          bit_index_nxt = bit_inc;
          if (bit_inc < BYTE_BITS) begin
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = slot_one_r;
          end else begin
            busy_nxt = 1'b0;
            op_nxt   = OP_FREE;
            done_nxt = 1'b1;
          end
        end
        OP_RESET: begin
          busy_nxt = 1'b0;
          if (!reset_phase_r) begin
            reset_phase_nxt = 1'b1;
            presence_nxt    = in_data_r;
            slow_baud_nxt   = 1'b0;
            op_nxt          = OP_FREE;
            done_nxt        = 1'b1;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r          <= OP_FREE;
      busy_r        <= 1'b0;
      bit_index_r   <= 4'd0;
      write_shift_r <= 8'h00;
      read_accum_r  <= 8'h00;
      presence_r    <= 8'h00;
      reset_phase_r <= 1'b0;
      slow_baud_r   <= 1'b0;
    end else if (advance) begin
      op_r          <= op_nxt;
      busy_r        <= busy_nxt;
      bit_index_r   <= bit_index_nxt;
      write_shift_r <= write_shift_nxt;
      read_accum_r  <= read_accum_nxt;
      presence_r    <= presence_nxt;
      reset_phase_r <= reset_phase_nxt;
      slow_baud_r   <= slow_baud_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // The presence test compares against the reset pattern as it stands now.
  always_ff @(posedge clk) begin
    if (advance) begin
      status_r   <= status_nxt;
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      done_r     <= done_nxt;
      present_r  <= (presence_nxt != reset_pat_r) && (presence_nxt != 8'h00);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_tx_valid       = tx_valid_r;
  assign out_tx_byte        = tx_byte_r;
  assign out_baud_slow      = slow_baud_r;
  assign out_done_res       = done_r;
  assign out_read_value     = read_accum_r;
  assign out_device_present = present_r;
  assign out_busy_flag      = busy_r;

`include "assert_macros.svh"

  // The busy flag and the operation register always agree.
  `ASSERT_SAME(a_busy_op, clk, rst_n, 1'b1, busy_r == (op_r != OP_FREE))
  // A slot byte and completion never come with the same result.
  `ASSERT_SAME(a_tx_done, clk, rst_n, out_valid_r && tx_valid_r, !done_r)
  // A refused command leaves the sequencer busy and sends nothing.
  `ASSERT_SAME(a_refused, clk, rst_n, out_valid_r && status_r, !tx_valid_r && busy_r)
  // Slow baud is only selected while a bus reset is running.
  `ASSERT_SAME(a_slow_reset, clk, rst_n, slow_baud_r, busy_r && op_r == OP_RESET)
  // A stalled result is followed by a valid result.
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r)

endmodule
